>>> design/tmpow_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmpow_pkg: shared types and constants for the matrix power core
// Payload structs, controller/datapath command and status groups, register
// codes and the Q2.30 round-and-saturate function.
// ----------------------------------------------------------------------------
package tmpow_pkg;

  // Fixed-point geometry
  localparam int ELEM_W     = 32;   // Q2.30 element
  localparam int FRAC_W     = 30;
  localparam int PROD_W     = 64;   // exact Q4.60 product
  localparam int ACC_W      = 67;   // exact sum of up to eight products
  localparam int SIDE_IDX_W = 3;    // index field width for the largest side

  // Configuration register codes (word index from paddr[2])
  localparam logic REG_STATE_COUNT = 1'b0;
  localparam logic REG_EXPONENT    = 1'b1;

  localparam logic [3:0]  STATE_COUNT_RESET = 4'd8;
  localparam logic [15:0] EXPONENT_RESET    = 16'd1;

  // Lane memory banks: copy of the loaded row, then two ping-pong banks
  typedef logic [1:0] bank_t;
  localparam bank_t BANK_BASE = 2'd0;
  localparam bank_t BANK_A    = 2'd1;
  localparam bank_t BANK_B    = 2'd2;

  // Rounding and saturation bounds
  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(64'sd536870912);
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(64'sd2305843009213693952);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI;
  localparam logic signed [ELEM_W-1:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [ELEM_W-1:0] Q_MIN   = 32'sh8000_0000;

  // Channel payloads
  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic                     final_element;
  } load_item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] product_element;
    logic                     last_of_run;
  } result_item_t;

  // Controller to datapath
  typedef struct packed {
    logic                  load_wr;
    logic [SIDE_IDX_W-1:0] load_row;
    logic [SIDE_IDX_W-1:0] load_col;
    logic                  mul_issue;
    logic                  mul_first;
    logic                  mul_last;
    logic [SIDE_IDX_W-1:0] mul_k;
    logic [SIDE_IDX_W-1:0] mul_col;
    bank_t                 bank_src;
    bank_t                 bank_dst;
    logic                  out_issue;
    logic                  out_last;
    logic [SIDE_IDX_W-1:0] out_row;
    logic [SIDE_IDX_W-1:0] out_col;
  } tmpow_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic out_pend;
    logic out_can_issue;
  } tmpow_status_t;

  // Round half up to Q2.30, then saturate
  function automatic logic signed [ELEM_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0] t;
    t = acc + RND_BIAS;
    if (t >= SAT_HI) begin
      return Q_MAX;
    end else if (t < SAT_LO) begin
      return Q_MIN;
    end
    return $signed(t[FRAC_W+ELEM_W-1:FRAC_W]);
  endfunction

endpackage
`default_nettype wire

>>> design/tmpow_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmpow_datapath: storage and multiply-accumulate lanes
// One lane per matrix row with its own row memory; a shared base-matrix
// memory broadcasts one column element a cycle; output register to the sink.
// ----------------------------------------------------------------------------
module tmpow_datapath #(
  parameter int MAX_STATES = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire tmpow_pkg::tmpow_cmd_t     cmd,
  input  wire logic signed [31:0]        load_element,
  output tmpow_pkg::tmpow_status_t       status,
  output logic                           result_valid,
  input  wire logic                      result_ready,
  output tmpow_pkg::result_item_t        result_item
);
  import tmpow_pkg::*;

  localparam int IDX_W      = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int LANE_AW    = IDX_W + 2;
  localparam int LANE_DEPTH = 3 << IDX_W;
  localparam int BASE_DEPTH = 1 << (2 * IDX_W);

  // Base matrix memory, addressed {row, col}
  logic signed [ELEM_W-1:0] base_mem [BASE_DEPTH];
  logic signed [ELEM_W-1:0] base_rdata;

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      base_mem[{cmd.load_row[IDX_W-1:0], cmd.load_col[IDX_W-1:0]}] <= load_element;
    end
    if (cmd.mul_issue) begin
      base_rdata <= base_mem[{cmd.mul_k[IDX_W-1:0], cmd.mul_col[IDX_W-1:0]}];
    end
  end

  // Pipeline tags: read, multiply, accumulate, write back
  logic             s1_valid, s1_first, s1_last;
  logic [IDX_W-1:0] s1_col;
  logic             s2_valid, s2_first, s2_last;
  logic [IDX_W-1:0] s2_col;
  logic             s3_done;
  logic [IDX_W-1:0] s3_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_done  <= 1'b0;
    end else begin
      s1_valid <= cmd.mul_issue;
      s2_valid <= s1_valid;
      s3_done  <= s2_valid && s2_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= cmd.mul_first;
    s1_last  <= cmd.mul_last;
    s1_col   <= cmd.mul_col[IDX_W-1:0];
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_col   <= s1_col;
    s3_col   <= s2_col;
  end

  // Lanes
  logic signed [ELEM_W-1:0] lane_rdata [MAX_STATES];
  logic signed [PROD_W-1:0] prod       [MAX_STATES];
  logic signed [ACC_W-1:0]  acc        [MAX_STATES];
  logic                     rd_en;

  assign rd_en = cmd.mul_issue || cmd.out_issue;

  for (genvar r = 0; r < MAX_STATES; r++) begin : g_lane
    logic signed [ELEM_W-1:0] lane_mem [LANE_DEPTH];
    logic                     load_hit;
    logic                     wr_en;
    logic [LANE_AW-1:0]       wr_addr;
    logic [LANE_AW-1:0]       rd_addr;
    logic signed [ELEM_W-1:0] wr_data;

    // write port: row copy on load, rounded dot product on write back
    always_comb begin
      load_hit = cmd.load_wr && (cmd.load_row[IDX_W-1:0] == IDX_W'(r));
      wr_en    = load_hit || s3_done;
      if (load_hit) begin
        wr_addr = {BANK_BASE, cmd.load_col[IDX_W-1:0]};
        wr_data = load_element;
      end else begin
        wr_addr = {cmd.bank_dst, s3_col};
        wr_data = round_sat(acc[r]);
      end
      if (cmd.mul_issue) begin
        rd_addr = {cmd.bank_src, cmd.mul_k[IDX_W-1:0]};
      end else begin
        rd_addr = {cmd.bank_src, cmd.out_col[IDX_W-1:0]};
      end
    end

    always_ff @(posedge clk) begin
      if (wr_en) begin
        lane_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        lane_rdata[r] <= lane_mem[rd_addr];
      end
    end

    // multiply, then accumulate at full width
    always_ff @(posedge clk) begin
      if (s1_valid) begin
        prod[r] <= lane_rdata[r] * base_rdata;
      end
      if (s2_valid) begin
        acc[r] <= s2_first ? ACC_W'(prod[r]) : acc[r] + ACC_W'(prod[r]);
      end
    end
  end

  // Result read pending and output register
  logic             pend;
  logic             pend_last;
  logic [IDX_W-1:0] pend_row;
  logic             out_free;

  assign out_free             = !result_valid || result_ready;
  assign status.out_can_issue = !pend || out_free;
  assign status.out_pend      = pend;
  assign status.pipe_busy     = s1_valid || s2_valid || s3_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.out_issue) begin
        pend <= 1'b1;
      end else if (out_free) begin
        pend <= 1'b0;
      end
      if (pend && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_issue) begin
      pend_row  <= cmd.out_row[IDX_W-1:0];
      pend_last <= cmd.out_last;
    end
    if (pend && out_free) begin
      result_item.product_element <= lane_rdata[pend_row];
      result_item.last_of_run     <= pend_last;
    end
  end

endmodule
`default_nettype wire

>>> design/tmpow_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmpow_ctrl: sequencer for load, multiply passes and result read-out
// Tracks the load position, walks column/inner-index pairs for each pass,
// swaps ping-pong banks between passes and issues result reads.
// ----------------------------------------------------------------------------
module tmpow_ctrl #(
  parameter int MAX_STATES = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [3:0]               state_count,
  input  wire logic [15:0]              exponent,
  input  wire logic                     cfg_wr,
  input  wire logic                     side_wr,
  input  wire logic                     load_valid,
  input  wire logic                     load_final,
  output logic                          load_ready,
  output tmpow_pkg::tmpow_cmd_t         cmd,
  input  wire tmpow_pkg::tmpow_status_t status
);
  import tmpow_pkg::*;

  localparam int IDX_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int NW    = $clog2(MAX_STATES + 1);
  localparam int CNT_W = $clog2(MAX_STATES * MAX_STATES + 1);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_ALIGN = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [2:0]       state;
  logic [CNT_W-1:0] ld_pos, walk;
  logic [IDX_W-1:0] ld_row, ld_col;
  logic [IDX_W-1:0] cnt_hi, cnt_lo;
  bank_t            src, dst;
  logic [15:0]      pass, mults;

  logic [NW-1:0]    n;
  logic [CNT_W-1:0] cells;
  logic             accept, ld_col_last, lo_last, hi_last;

  // Side length in use, clamped to 1..MAX_STATES
  always_comb begin
    if (state_count == 4'd0) begin
      n = NW'(1);
    end else if (state_count > 4'(MAX_STATES)) begin
      n = NW'(MAX_STATES);
    end else begin
      n = NW'(state_count);
    end
    cells = CNT_W'(n) * CNT_W'(n);
  end

  assign ld_col_last = (NW'(ld_col) + NW'(1)) == n;
  assign lo_last     = (NW'(cnt_lo) + NW'(1)) == n;
  assign hi_last     = (NW'(cnt_hi) + NW'(1)) == n;

  assign load_ready = (state == ST_LOAD) && !cfg_wr;
  assign accept     = load_valid && load_ready;

  // Commands
  always_comb begin
    cmd           = '0;
    cmd.load_wr   = accept && (ld_pos < cells);
    cmd.load_row  = SIDE_IDX_W'(ld_row);
    cmd.load_col  = SIDE_IDX_W'(ld_col);
    cmd.mul_issue = (state == ST_MUL);
    cmd.mul_first = (cnt_lo == '0);
    cmd.mul_last  = lo_last;
    cmd.mul_k     = SIDE_IDX_W'(cnt_lo);
    cmd.mul_col   = SIDE_IDX_W'(cnt_hi);
    cmd.bank_src  = src;
    cmd.bank_dst  = dst;
    cmd.out_issue = (state == ST_OUT) && status.out_can_issue;
    cmd.out_last  = hi_last && lo_last;
    cmd.out_row   = SIDE_IDX_W'(cnt_hi);
    cmd.out_col   = SIDE_IDX_W'(cnt_lo);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_LOAD;
      ld_pos <= '0;
      ld_row <= '0;
      ld_col <= '0;
      walk   <= '0;
      cnt_hi <= '0;
      cnt_lo <= '0;
      src    <= BANK_BASE;
      dst    <= BANK_A;
      pass   <= '0;
      mults  <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (side_wr) begin
            // side changed mid-load: recompute row and column of ld_pos
            state  <= ST_ALIGN;
            walk   <= '0;
            ld_row <= '0;
            ld_col <= '0;
          end else if (accept) begin
            if (ld_pos < cells) begin
              ld_pos <= ld_pos + CNT_W'(1);
              if (ld_col_last) begin
                ld_col <= '0;
                ld_row <= ld_row + IDX_W'(1);
              end else begin
                ld_col <= ld_col + IDX_W'(1);
              end
            end
            if (load_final) begin
              ld_pos <= '0;
              ld_row <= '0;
              ld_col <= '0;
              cnt_hi <= '0;
              cnt_lo <= '0;
              src    <= BANK_BASE;
              dst    <= BANK_A;
              pass   <= '0;
              if (exponent >= 16'd2) begin
                mults <= exponent - 16'd1;
                state <= ST_MUL;
              end else begin
                mults <= '0;
                state <= ST_OUT;
              end
            end
          end
        end

        ST_ALIGN: begin
          if (side_wr) begin
            walk   <= '0;
            ld_row <= '0;
            ld_col <= '0;
          end else if (walk == ld_pos || walk == cells) begin
            state <= ST_LOAD;
          end else begin
            walk <= walk + CNT_W'(1);
            if (ld_col_last) begin
              ld_col <= '0;
              ld_row <= ld_row + IDX_W'(1);
            end else begin
              ld_col <= ld_col + IDX_W'(1);
            end
          end
        end

        ST_MUL: begin
          // inner index fastest, then column
          if (lo_last) begin
            cnt_lo <= '0;
            if (hi_last) begin
              cnt_hi <= '0;
              state  <= ST_DRAIN;
            end else begin
              cnt_hi <= cnt_hi + IDX_W'(1);
            end
          end else begin
            cnt_lo <= cnt_lo + IDX_W'(1);
          end
        end

        ST_DRAIN: begin
          if (!status.pipe_busy) begin
            src  <= dst;
            dst  <= (dst == BANK_A) ? BANK_B : BANK_A;
            pass <= pass + 16'd1;
            if (pass + 16'd1 == mults) begin
              state <= ST_OUT;
            end else begin
              state <= ST_MUL;
            end
          end
        end

        ST_OUT: begin
          if (cmd.out_issue) begin
            if (lo_last) begin
              cnt_lo <= '0;
              if (hi_last) begin
                cnt_hi <= '0;
                state  <= ST_FLUSH;
              end else begin
                cnt_hi <= cnt_hi + IDX_W'(1);
              end
            end else begin
              cnt_lo <= cnt_lo + IDX_W'(1);
            end
          end
        end

        ST_FLUSH: begin
          if (!status.out_pend) begin
            state <= ST_LOAD;
          end
        end

        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/transition_matrix_power_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// transition_matrix_power_core: matrix power by repeated multiplication
// Loads an n x n Q2.30 matrix, raises it to the configured power (exponent
// 0 acts as 1) with one MAC lane per row, and streams the result row-major.
// ----------------------------------------------------------------------------
// Load: one element per cycle when load_ready is high. After the marked
// element each multiplication pass walks n*n column/inner-index pairs (one
// MAC lane per row, one base-memory read a cycle), then drains, repeated
// exponent-1 times; results then stream at one per cycle when result_ready
// is high. A state_count write mid-load re-derives the load row and column.
// Reset (rst, synchronous): state_count = 8, exponent = 1, load position 0.
module transition_matrix_power_core #(
  parameter int MAX_STATES = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // configuration
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [2:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // matrix elements
  input  wire logic                    load_valid,
  output logic                         load_ready,
  input  wire tmpow_pkg::load_item_t   load_item,
  // power elements
  output logic                         result_valid,
  input  wire logic                    result_ready,
  output tmpow_pkg::result_item_t      result_item
);
  import tmpow_pkg::*;

  logic [3:0]    state_count;
  logic [15:0]   exponent;
  logic          cfg_wr, side_wr;
  tmpow_cmd_t    cmd;
  tmpow_status_t status;

  // Register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign side_wr = cfg_wr && (paddr[2] == REG_STATE_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state_count <= STATE_COUNT_RESET;
      exponent    <= EXPONENT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_STATE_COUNT: state_count <= pwdata[3:0];
        REG_EXPONENT:    exponent    <= pwdata[15:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_STATE_COUNT: prdata = {28'd0, state_count};
      REG_EXPONENT:    prdata = {16'd0, exponent};
      default:         prdata = '0;
    endcase
  end

  tmpow_ctrl #(
    .MAX_STATES (MAX_STATES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .state_count (state_count),
    .exponent    (exponent),
    .cfg_wr      (cfg_wr),
    .side_wr     (side_wr),
    .load_valid  (load_valid),
    .load_final  (load_item.final_element),
    .load_ready  (load_ready),
    .cmd         (cmd),
    .status      (status)
  );

  tmpow_datapath #(
    .MAX_STATES (MAX_STATES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .load_element (load_item.element),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule
`default_nettype wire

>>> design/tmpow_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmpow_checker: port-level checks for the matrix power core
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module tmpow_checker (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    psel,
  input wire logic                    penable,
  input wire logic                    pwrite,
  input wire logic                    load_valid,
  input wire logic                    load_ready,
  input wire tmpow_pkg::load_item_t   load_item,
  input wire logic                    result_valid,
  input wire logic                    result_ready,
  input wire tmpow_pkg::result_item_t result_item
);
  import tmpow_pkg::*;

  // a stalled result transaction holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_item))
    else $error("result changed while stalled");

  // nothing is offered straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // no element is taken in the cycle a register write completes
  a_cfg_blocks_load: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |-> !load_ready)
    else $error("element accepted alongside a register write");

  // the marked element starts a run: loading stops
  a_mark_starts_run: assert property (@(posedge clk) disable iff (rst)
    load_valid && load_ready && load_item.final_element |=> !load_ready)
    else $error("load still open after the last element");

endmodule

bind transition_matrix_power_core tmpow_checker u_tmpow_checker (
  .clk          (clk),
  .rst          (rst),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .load_valid   (load_valid),
  .load_ready   (load_ready),
  .load_item    (load_item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_item  (result_item)
);
`default_nettype wire
